### hw/rtl/assert_macros.svh
// Assertion macros shared by the rate meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPLIES(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### hw/rtl/wprm_pkg.sv
// Shared types, constants and helpers of the windowed packet rate meter.
package wprm_pkg;

    localparam int FRAMES_DEF     = 64;
    localparam int DIRECTIONS_DEF = 2;

    localparam logic [15:0] WINDOW_RESET = 16'd1000;
    localparam logic [6:0]  CNT_MAX      = 7'd127;

    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_BYTES  = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic KIND_SNAPSHOT = 1'b0;

    // One ring entry as stored in memory.
    typedef struct packed {
        logic [31:0] ts;
        logic [15:0] pkt;
        logic [31:0] snap;
        logic [31:0] game;
    } entry_t;

    // Sequencer to accumulator control.
    typedef struct packed {
        logic clear;
        logic en;
        logic live;
    } acc_ctl_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

### hw/rtl/wprm_store.sv
// Ring entry memory: one write port, one registered read port.
module wprm_store #(
    parameter int AW = 7
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  wprm_pkg::entry_t    wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output wprm_pkg::entry_t    rd_data
);

    localparam int DEPTH = 1 << AW;

    wprm_pkg::entry_t mem [DEPTH];
    wprm_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/wprm_acc.sv
// Window accumulator: timestamp compare plus saturating sums, one entry per cycle.
module wprm_acc #(
    parameter int FRAMES = wprm_pkg::FRAMES_DEF
) (
    input  logic                clk,
    input  wprm_pkg::acc_ctl_t  ctl,
    input  wprm_pkg::entry_t    entry,
    input  logic [31:0]         limit,
    output logic [6:0]          count,
    output logic [31:0]         bytes_sum,
    output logic [31:0]         snap_sum,
    output logic [31:0]         game_sum
);

    localparam int CW = ($clog2(FRAMES + 1) > 7) ? $clog2(FRAMES + 1) : 8;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [31:0]   bytes_reg;
    logic [31:0]   bytes_next;
    logic [31:0]   snap_reg;
    logic [31:0]   snap_next;
    logic [31:0]   game_reg;
    logic [31:0]   game_next;
    logic          hit;

    // Unwritten entries are masked by live, never by their stored timestamp.
    assign hit = ctl.en && ctl.live && (entry.ts > limit);

    always_comb
    begin
        cnt_next   = cnt_reg;
        bytes_next = bytes_reg;
        snap_next  = snap_reg;
        game_next  = game_reg;
        if (ctl.clear)
        begin
            cnt_next   = '0;
            bytes_next = '0;
            snap_next  = '0;
            game_next  = '0;
        end
        else if (hit)
        begin
            cnt_next   = cnt_reg + 1'b1;
            bytes_next = wprm_pkg::sat_add32(bytes_reg, {16'd0, entry.pkt});
            snap_next  = wprm_pkg::sat_add32(snap_reg, entry.snap);
            game_next  = wprm_pkg::sat_add32(game_reg, entry.game);
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        bytes_reg <= bytes_next;
        snap_reg  <= snap_next;
        game_reg  <= game_next;
    end

    assign count     = (cnt_reg > CW'(wprm_pkg::CNT_MAX)) ? wprm_pkg::CNT_MAX : cnt_reg[6:0];
    assign bytes_sum = bytes_reg;
    assign snap_sum  = snap_reg;
    assign game_sum  = game_reg;

endmodule

### hw/rtl/windowed_packet_rate_meter.sv
// Windowed packet rate meter top level: sequencer, per-direction ring state, output register.
// Each direction keeps a ring of FRAMES packet records in one shared memory. A packet
// transaction is a single write; a sample-bytes transaction is a read-modify-write
// through the memory read and write ports (it is dropped when its direction has
// no packet yet), and a query walks the ring, reading one ring entry per cycle through
// the memory read port into the shared compare/accumulate unit; then the result is
// loaded into the output register. A query that finishes while the previous result is
// still stalled waits until it is taken. Input is stalled while a transaction is in
// progress. Written entries are tracked by a fill count per direction, so no clearing
// pass is needed after reset.
module windowed_packet_rate_meter #(
    parameter int FRAMES     = wprm_pkg::FRAMES_DEF,
    parameter int DIRECTIONS = wprm_pkg::DIRECTIONS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic        direction,
    input  logic        sample_kind,
    input  logic [15:0] byte_count,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  packets_in_window,
    output logic [31:0] bytes_in_window,
    output logic [31:0] snapshot_bytes_in_window,
    output logic [31:0] gamedata_bytes_in_window,
    output logic [15:0] latest_packet_bytes
);

`include "assert_macros.svh"

    localparam int FW  = $clog2(FRAMES);
    localparam int DW  = (DIRECTIONS > 1) ? $clog2(DIRECTIONS) : 1;
    localparam int FCW = $clog2(FRAMES + 1);
    localparam int AW  = DW + FW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BYTES,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [15:0]    window_reg;
    logic [15:0]    window_next;
    logic [FW-1:0]  idx_reg;
    logic [FW-1:0]  idx_next;
    logic           en_reg;
    logic           en_next;
    logic           live_reg;
    logic           live_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [FW-1:0]  ptr_reg    [DIRECTIONS];
    logic [FW-1:0]  ptr_next   [DIRECTIONS];
    logic [FCW-1:0] fill_reg   [DIRECTIONS];
    logic [FCW-1:0] fill_next  [DIRECTIONS];
    logic [15:0]    latest_reg [DIRECTIONS];
    logic [15:0]    latest_next[DIRECTIONS];

    logic [DW-1:0]  dir_reg;
    logic [31:0]    limit_reg;
    logic           kind_reg;
    logic [15:0]    bytes_reg;
    logic [6:0]     o_cnt_reg;
    logic [31:0]    o_bytes_reg;
    logic [31:0]    o_snap_reg;
    logic [31:0]    o_game_reg;
    logic [15:0]    o_latest_reg;

    logic              in_take;
    logic              dir_ok;
    logic              out_free;
    logic              out_load;
    logic              query_go;
    logic              walk_phase;
    logic [DW-1:0]     cur_dir;
    logic [FW-1:0]     cur_ptr;
    logic [FCW-1:0]    cur_fill;
    logic [FW-1:0]     new_ptr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    wprm_pkg::entry_t  wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    wprm_pkg::entry_t  rd_data;
    wprm_pkg::acc_ctl_t acc_ctl;
    logic [6:0]        acc_cnt;
    logic [31:0]       acc_bytes;
    logic [31:0]       acc_snap;
    logic [31:0]       acc_game;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_take    = in_valid && (state_reg == ST_IDLE);
    assign dir_ok     = ({31'd0, direction} < 32'(DIRECTIONS));
    assign cur_dir    = (state_reg == ST_IDLE) ? DW'(direction) : dir_reg;
    assign cur_ptr    = ptr_reg[cur_dir];
    assign cur_fill   = fill_reg[cur_dir];
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_load   = (state_reg == ST_FINISH) && out_free;
    assign query_go   = in_take && dir_ok && (opcode == wprm_pkg::OP_QUERY);
    assign walk_phase = (state_reg == ST_WALK) || (state_reg == ST_DRAIN);

    // First packet lands at entry 0; later ones advance with wrap.
    assign new_ptr = (cur_fill == '0) ? '0 :
                     (cur_ptr == FW'(FRAMES - 1)) ? '0 : cur_ptr + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        window_next    = cfg_wr_en ? cfg_wr_data : window_reg;
        idx_next       = idx_reg;
        en_next        = 1'b0;
        live_next      = 1'b0;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        latest_next    = latest_reg;
        out_valid_next = out_valid_reg && out_stall;
        wr_en          = 1'b0;
        wr_addr        = {cur_dir, cur_ptr};
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = {cur_dir, cur_ptr};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && dir_ok)
                begin
                    case (opcode)
                        wprm_pkg::OP_PACKET:
                        begin
                            wr_en        = 1'b1;
                            wr_addr      = {cur_dir, new_ptr};
                            wr_data.ts   = now_ms;
                            wr_data.pkt  = byte_count;
                            wr_data.snap = '0;
                            wr_data.game = '0;
                            ptr_next[cur_dir]    = new_ptr;
                            fill_next[cur_dir]   = (cur_fill == FCW'(FRAMES)) ?
                                                   cur_fill : cur_fill + 1'b1;
                            latest_next[cur_dir] = byte_count;
                        end
                        wprm_pkg::OP_BYTES:
                        begin
                            if (cur_fill != '0)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_BYTES;
                            end
                        end
                        wprm_pkg::OP_QUERY:
                        begin
                            idx_next   = '0;
                            state_next = ST_WALK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_BYTES:
            begin
                wr_en = 1'b1;
                if (kind_reg == wprm_pkg::KIND_SNAPSHOT)
                begin
                    wr_data.snap = wprm_pkg::sat_add32(rd_data.snap, {16'd0, bytes_reg});
                end
                else
                begin
                    wr_data.game = wprm_pkg::sat_add32(rd_data.game, {16'd0, bytes_reg});
                end
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                rd_en     = 1'b1;
                rd_addr   = {dir_reg, idx_reg};
                en_next   = 1'b1;
                live_next = (FCW'(idx_reg) < cur_fill);
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == FW'(FRAMES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= wprm_pkg::WINDOW_RESET;
            idx_reg       <= '0;
            en_reg        <= 1'b0;
            live_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            o_cnt_reg     <= '0;
            o_bytes_reg   <= '0;
            o_snap_reg    <= '0;
            o_game_reg    <= '0;
            o_latest_reg  <= '0;
            for (int d = 0; d < DIRECTIONS; d++)
            begin
                ptr_reg[d]    <= '0;
                fill_reg[d]   <= '0;
                latest_reg[d] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            idx_reg       <= idx_next;
            en_reg        <= en_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            latest_reg    <= latest_next;
            if (out_load)
            begin
                o_cnt_reg    <= acc_cnt;
                o_bytes_reg  <= acc_bytes;
                o_snap_reg   <= acc_snap;
                o_game_reg   <= acc_game;
                o_latest_reg <= latest_reg[cur_dir];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dir_reg   <= DW'(direction);
            limit_reg <= now_ms - {16'd0, window_reg};
            kind_reg  <= sample_kind;
            bytes_reg <= byte_count;
        end
    end

    assign acc_ctl.clear = query_go;
    assign acc_ctl.en    = en_reg;
    assign acc_ctl.live  = live_reg;

    wprm_store #(
        .AW (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wprm_acc #(
        .FRAMES (FRAMES)
    ) u_acc (
        .clk       (clk),
        .ctl       (acc_ctl),
        .entry     (rd_data),
        .limit     (limit_reg),
        .count     (acc_cnt),
        .bytes_sum (acc_bytes),
        .snap_sum  (acc_snap),
        .game_sum  (acc_game)
    );

    assign out_valid                = out_valid_reg;
    assign packets_in_window        = o_cnt_reg;
    assign bytes_in_window          = o_bytes_reg;
    assign snapshot_bytes_in_window = o_snap_reg;
    assign gamedata_bytes_in_window = o_game_reg;
    assign latest_packet_bytes      = o_latest_reg;

    `ASSERT_IMPLIES(a_res_src, $rose(out_valid_reg), $past(state_reg == ST_FINISH), "stray result")
    `ASSERT_IMPLIES(a_acc_walk, acc_ctl.en, walk_phase, "accumulate outside walk")
    `ASSERT_IMPLIES(a_walk_idx, state_reg == ST_WALK, idx_reg <= FW'(FRAMES - 1), "idx past ring")
    `ASSERT_NEXT(a_hold, state_reg == ST_FINISH && !out_free, state_reg == ST_FINISH, "result lost")

endmodule
